// ===== design/pfba_pkg.sv =====
// Shared constants and types for the page frame bitmap allocator.
package pfba_pkg;

    localparam int BITMAP_WORDS = 1024;
    localparam int WORD_BITS    = 32;

    localparam int FRAME_W   = 20;
    localparam int WORDS_W   = 11;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 20;

    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int ADDR_W  = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int CNT_W   = $clog2(BITMAP_WORDS + 1);
    localparam int REL_W   = FRAME_W - BIT_W;
    localparam int CLAMP_W = (WORDS_W > CNT_W) ? WORDS_W : CNT_W;
    localparam int CMP_W   = (REL_W > CNT_W) ? REL_W : CNT_W;
    localparam int IDX_W   = ADDR_W + BIT_W;

    localparam logic [WORDS_W-1:0] WORDS_RESET = WORDS_W'(1024);
    localparam logic [FRAME_W-1:0] BASE_RESET  = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY   = 2'd0,
        CMD_RESERVE = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FREE_BASE_FRAME = 1'b0,
        REG_WORDS_IN_USE    = 1'b1
    } cfg_idx_t;

endpackage

// ===== design/page_frame_bitmap_allocator.sv =====
// Bitmap page frame allocator: frame bitmap store, scan sequencer and result register.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_cmd, s_frame_number
//  m_      | out       | m_valid / m_ready  | m_free_frame, m_found, m_status
//  cfg_    | in        | cfg_we             | cfg_index, cfg_wdata
//
// Query: the covered words are read in order until one with a clear bit is found;
// one bitmap word is read and checked per cycle on the one port.
// Reserve and release: read-modify-write on the one port (read in S_IDLE, write in S_RMW).
// The next request is taken the cycle after a result is loaded.
// After reset a clearing pass zeros all 1024 words, one per cycle; requests wait,
// config writes do not. A held result stalls only the following result.
module page_frame_bitmap_allocator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [pfba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfba_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [pfba_pkg::CMD_W-1:0]         s_cmd,
    input  logic [pfba_pkg::FRAME_W-1:0]       s_frame_number,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [pfba_pkg::FRAME_W-1:0]       m_free_frame,
    output logic                               m_found,
    output logic                               m_status
);
    import pfba_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RMW,
        S_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [FRAME_W-1:0]   base_reg, base_next;
    logic [WORDS_W-1:0]   words_reg, words_next;
    logic [ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [ADDR_W-1:0]    rd_word_reg, rd_word_next;
    logic [ADDR_W-1:0]    word_reg, word_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic                 set_reg, set_next;
    logic [FRAME_W-1:0]   res_frame_reg, res_frame_next;
    logic                 res_found_reg, res_found_next;
    logic                 res_status_reg, res_status_next;
    logic                 m_valid_reg, m_valid_next;
    logic [FRAME_W-1:0]   m_frame_reg, m_frame_next;
    logic                 m_found_reg, m_found_next;
    logic                 m_status_reg, m_status_next;

    logic [WORD_BITS-1:0] bitmap_mem [BITMAP_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 mem_we;

    logic [CNT_W-1:0]     cover_cnt;
    logic                 loc_ok;
    logic [FRAME_W-1:0]   rel_frame;
    logic [REL_W-1:0]     rel_word;
    logic [ADDR_W-1:0]    loc_word;
    logic [BIT_W-1:0]     loc_bit;
    logic [BIT_W-1:0]     lz_bit;
    logic                 issue;
    logic [IDX_W-1:0]     hit_idx;
    logic [WORD_BITS-1:0] bit_mask;
    cmd_t                 cmd;

    assign cmd = cmd_t'(s_cmd);

    always_comb begin
        if (CLAMP_W'(words_reg) > CLAMP_W'(BITMAP_WORDS)) begin
            cover_cnt = CNT_W'(BITMAP_WORDS);
        end else begin
            cover_cnt = CNT_W'(words_reg);
        end
    end

    // absolute frame -> word / bit, with range check
    assign rel_frame = s_frame_number - base_reg;
    assign rel_word  = rel_frame[FRAME_W-1:BIT_W];
    assign loc_word  = ADDR_W'(rel_word);
    assign loc_bit   = rel_frame[BIT_W-1:0];
    assign loc_ok    = (s_frame_number >= base_reg) &&
                       (CMP_W'(rel_word) < CMP_W'(cover_cnt));

    // lowest clear bit of the word under check
    always_comb begin
        lz_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!rd_data_reg[i]) begin
                lz_bit = BIT_W'(i);
            end
        end
    end

    assign hit_idx  = {rd_word_reg, lz_bit};
    assign issue    = scan_cnt_reg < cover_cnt;
    assign bit_mask = WORD_BITS'(1) << bit_reg;

    always_comb begin
        state_next      = state_reg;
        base_next       = base_reg;
        words_next      = words_reg;
        clr_cnt_next    = clr_cnt_reg;
        scan_cnt_next   = scan_cnt_reg;
        rd_pend_next    = rd_pend_reg;
        rd_word_next    = rd_word_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        set_next        = set_reg;
        res_frame_next  = res_frame_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_frame_next    = m_frame_reg;
        m_found_next    = m_found_reg;
        m_status_next   = m_status_reg;
        mem_we          = 1'b0;
        wr_addr         = word_reg;
        wr_data         = rd_data_reg;
        rd_addr         = ADDR_W'(scan_cnt_reg);

        if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_FREE_BASE_FRAME: base_next  = FRAME_W'(cfg_wdata);
                REG_WORDS_IN_USE:    words_next = WORDS_W'(cfg_wdata);
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                mem_we       = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(BITMAP_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                rd_addr = loc_word;
                if (s_valid) begin
                    res_frame_next  = '0;
                    res_found_next  = 1'b0;
                    res_status_next = 1'b0;
                    unique case (cmd)
                        CMD_QUERY: begin
                            scan_cnt_next = '0;
                            rd_pend_next  = 1'b0;
                            state_next    = S_SCAN;
                        end
                        CMD_RESERVE, CMD_RELEASE: begin
                            if (loc_ok) begin
                                word_next  = loc_word;
                                bit_next   = loc_bit;
                                set_next   = (cmd == CMD_RESERVE);
                                state_next = S_RMW;
                            end else begin
                                res_status_next = 1'b1;
                                state_next      = S_OUT;
                            end
                        end
                        default: begin
                            res_status_next = 1'b1;
                            state_next      = S_OUT;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                rd_pend_next = issue;
                rd_word_next = rd_addr;
                if (issue) begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                if (rd_pend_reg && (rd_data_reg != '1)) begin
                    res_frame_next = FRAME_W'(hit_idx) + base_reg;
                    res_found_next = 1'b1;
                    state_next     = S_OUT;
                end else if (!rd_pend_reg && !issue) begin
                    state_next = S_OUT;
                end
            end
            S_RMW: begin
                mem_we     = 1'b1;
                wr_addr    = word_reg;
                wr_data    = set_reg ? (rd_data_reg | bit_mask) : (rd_data_reg & ~bit_mask);
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_frame_next  = res_frame_reg;
                    m_found_next  = res_found_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bitmap_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= bitmap_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            base_reg     <= BASE_RESET;
            words_reg    <= WORDS_RESET;
            clr_cnt_reg  <= '0;
            scan_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            words_reg    <= words_next;
            clr_cnt_reg  <= clr_cnt_next;
            scan_cnt_reg <= scan_cnt_next;
            rd_pend_reg  <= rd_pend_next;
            m_valid_reg  <= m_valid_next;
        end
        rd_word_reg    <= rd_word_next;
        word_reg       <= word_next;
        bit_reg        <= bit_next;
        set_reg        <= set_next;
        res_frame_reg  <= res_frame_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        m_frame_reg    <= m_frame_next;
        m_found_reg    <= m_found_next;
        m_status_reg   <= m_status_next;
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_free_frame = m_frame_reg;
    assign m_found      = m_found_reg;
    assign m_status     = m_status_reg;

endmodule
